// File: hdl/sspc_pkg.sv
// package with shared constants and types for the scanline scaler
`timescale 1ns / 1ps
package sspc_pkg;
  localparam int LineDepth = 4096;
  localparam int LineAw = $clog2(LineDepth);
  localparam int HistDepth = 256;
  localparam int HistAw = $clog2(HistDepth);
  localparam int DivW = 32;
  localparam logic [31:0] SumMax = 32'hFFFF_FFFF;
  localparam logic [23:0] CntMax = 24'hFF_FFFF;

  localparam logic [1:0] ReqLoad = 2'd0;
  localparam logic [1:0] ReqConv = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;
  localparam logic [1:0] ReqClear = 2'd3;

  localparam logic [1:0] ModeDirect = 2'd0;
  localparam logic [1:0] Mode565 = 2'd1;
  localparam logic [1:0] Mode555 = 2'd2;
  localparam logic [1:0] ModePal = 2'd3;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegEndian = 3'd1;
  localparam logic [2:0] RegBpp = 3'd2;
  localparam logic [2:0] RegSrcW = 3'd3;
  localparam logic [2:0] RegZoomW = 3'd4;
  localparam logic [2:0] RegXOff = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [15:0] pixel_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [3:0] byte_mask;
    logic [31:0] sum_red;
    logic [31:0] sum_green;
    logic [31:0] sum_blue;
    logic [23:0] hit_count;
    logic status;
  } rsp_t;
endpackage

// File: hdl/sspc_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
interface sspc_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hdl/scanline_scale_pixel_convert.sv
// top level: line store, histogram and restoring divider
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | req_type, pixel_index, red_in, green_in, blue_in
// rsp     | out | byte0..3, byte_mask, sum_red/green/blue, hit_count, status
// apb     | in  | six config registers at 4*i
// a convert runs a multiply, the restoring divider, a line store read and a
// pack; palette mode adds a histogram update; a flagged fetch ends early
// a histogram clear sweep over every entry follows reset before the first request
// one request at a time; the result register holds until taken
module scanline_scale_pixel_convert import sspc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sspc_if.sink req_i,
  sspc_if.source rsp_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam logic [3:0] StClr = 4'd0, StIdle = 4'd1, StMul = 4'd2, StDiv = 4'd3,
    StRd = 4'd4, StRdW = 4'd5, StPack = 4'd6, StHr = 4'd7, StHrW = 4'd8,
    StHupd = 4'd9, StOut = 4'd10;

  logic [1:0] mode_q;
  logic endian_q;
  logic [2:0] bpp_q;
  logic [12:0] srcw_q;
  logic [15:0] zoomw_q;
  logic [15:0] xoff_q;

  logic [3:0] st_q;
  req_t req_q;
  rsp_t rsp_q;
  logic [31:0] num_q, quo_q;
  logic [16:0] rem_q;
  logic [5:0] cnt_q;
  logic [HistAw:0] clr_q;
  logic [23:0] px_q;
  logic [7:0] m_q;

  // memories
  logic [23:0] line_mem [LineDepth];
  logic [119:0] hist_mem [HistDepth];
  logic [23:0] line_rd_q;
  logic [119:0] hist_rd_q;
  logic line_we, hist_we, line_re, hist_re;
  logic [LineAw-1:0] line_wa, line_ra;
  logic [HistAw-1:0] hist_wa, hist_ra;
  logic [119:0] hist_wd;

  // apb config
  assign pready = 1'b1;
  wire cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[4:2])
      RegMode: prdata = {30'd0, mode_q};
      RegEndian: prdata = {31'd0, endian_q};
      RegBpp: prdata = {29'd0, bpp_q};
      RegSrcW: prdata = {19'd0, srcw_q};
      RegZoomW: prdata = {16'd0, zoomw_q};
      RegXOff: prdata = {16'd0, xoff_q};
      default: prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDirect;
      endian_q <= 1'b0;
      bpp_q <= 3'd4;
      srcw_q <= 13'd4096;
      zoomw_q <= 16'd4096;
      xoff_q <= 16'd0;
    end else if (cfg_wr && paddr[1:0] == 2'd0) begin
      unique case (paddr[4:2])
        RegMode: mode_q <= pwdata[1:0];
        RegEndian: endian_q <= pwdata[0];
        RegBpp: bpp_q <= pwdata[2:0];
        RegSrcW: srcw_q <= pwdata[12:0];
        RegZoomW: zoomw_q <= pwdata[15:0];
        RegXOff: xoff_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_wa] <= {req_q.red_in, req_q.green_in, req_q.blue_in};
    if (line_re) line_rd_q <= line_mem[line_ra];
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_rd_q <= hist_mem[hist_ra];
  end

  // divider step
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rem_sh = {rem_q[15:0], num_q[31]};
  assign rem_sub = rem_sh - {1'b0, zoomw_q};

  // pack of the fetched pixel
  logic [7:0] r, g, b, lo, hi, pal;
  logic [10:0] r6, b6;
  logic [10:0] g7;
  assign r = px_q[23:16];
  assign g = px_q[15:8];
  assign b = px_q[7:0];
  assign r6 = 11'(r) * 11'd6;
  assign b6 = 11'(b) * 11'd6;
  assign g7 = 11'(g) * 11'd7;
  assign pal = 8'(g7[10:8]) * 8'd36 + 8'(r6[10:8]) * 8'd6 + 8'(b6[10:8]);
  always_comb begin
    if (mode_q == Mode565) begin
      lo = {g[4:2], b[7:3]};
      hi = {r[7:3], g[7:5]};
    end else begin
      lo = {g[5:3], b[7:3]};
      hi = {1'b0, r[7:3], g[7:6]};
    end
  end

  // saturating histogram sums
  logic [119:0] hupd;
  logic [32:0] sr, sg, sb;
  logic [24:0] sc;
  assign sr = {1'b0, hist_rd_q[119:88]} + 33'(r);
  assign sg = {1'b0, hist_rd_q[87:56]} + 33'(g);
  assign sb = {1'b0, hist_rd_q[55:24]} + 33'(b);
  assign sc = {1'b0, hist_rd_q[23:0]} + 25'd1;
  assign hupd = {sr[32] ? SumMax : sr[31:0], sg[32] ? SumMax : sg[31:0],
                 sb[32] ? SumMax : sb[31:0], sc[24] ? CntMax : sc[23:0]};

  always_comb begin
    line_we = 1'b0;
    line_wa = req_q.pixel_index[LineAw-1:0];
    line_re = st_q == StRd;
    line_ra = quo_q[LineAw-1:0];
    hist_we = 1'b0;
    hist_wa = m_q;
    hist_wd = hupd;
    hist_re = st_q == StHr;
    hist_ra = (req_q.req_type == ReqRead) ? req_q.pixel_index[HistAw-1:0] : m_q;
    if (st_q == StClr) begin
      hist_we = 1'b1;
      hist_wa = clr_q[HistAw-1:0];
      hist_wd = '0;
    end else if (st_q == StHupd) begin
      hist_we = 1'b1;
    end else if (st_q == StMul && req_q.req_type == ReqLoad
                 && req_q.pixel_index < 16'(LineDepth)) begin
      line_we = 1'b1;
    end else if (st_q == StMul && req_q.req_type == ReqClear
                 && req_q.pixel_index < 16'(HistDepth)) begin
      hist_we = 1'b1;
      hist_wa = req_q.pixel_index[HistAw-1:0];
      hist_wd = '0;
    end
  end

  assign req_i.ready = st_q == StIdle;
  assign rsp_o.valid = st_q == StOut;
  assign rsp_o.data = rsp_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      clr_q <= '0;
      cnt_q <= '0;
      req_q <= '0;
      rsp_q <= '0;
      num_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      px_q <= '0;
      m_q <= '0;
    end else begin
      unique case (st_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (HistAw+1)'(HistDepth - 1)) st_q <= StIdle;
        end
        StIdle: if (req_i.valid) begin
          req_q <= req_i.data;
          rsp_q <= '0;
          st_q <= StMul;
        end
        StMul: begin
          num_q <= (32'(req_q.pixel_index) + 32'(xoff_q)) * 32'(srcw_q);
          rem_q <= '0;
          cnt_q <= '0;
          unique case (req_q.req_type)
            ReqConv: st_q <= (zoomw_q == 16'd0) ? StOut : StDiv;
            ReqRead: st_q <= (req_q.pixel_index < 16'(HistDepth)) ? StHr : StOut;
            default: st_q <= StOut;
          endcase
          if ((req_q.req_type == ReqConv && zoomw_q == 16'd0) ||
              (req_q.req_type == ReqLoad && req_q.pixel_index >= 16'(LineDepth)) ||
              (req_q.req_type[1] && req_q.pixel_index >= 16'(HistDepth)))
            rsp_q.status <= 1'b1;
        end
        StDiv: begin
          num_q <= {num_q[30:0], 1'b0};
          if (!rem_sub[16]) begin
            rem_q <= rem_sub;
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(DivW - 1)) st_q <= StRd;
        end
        StRd: begin
          if (quo_q >= 32'(LineDepth)) begin
            rsp_q.status <= 1'b1;
            st_q <= StOut;
          end else st_q <= StRdW;
        end
        StRdW: begin
          px_q <= line_rd_q;
          st_q <= StPack;
        end
        StPack: begin
          m_q <= pal;
          st_q <= StOut;
          unique case (mode_q)
            ModeDirect: begin
              if (endian_q && bpp_q != 3'd3) begin
                rsp_q.byte1 <= r; rsp_q.byte2 <= g; rsp_q.byte3 <= b;
                rsp_q.byte_mask <= 4'hE;
              end else if (endian_q) begin
                rsp_q.byte0 <= r; rsp_q.byte1 <= g; rsp_q.byte2 <= b;
                rsp_q.byte_mask <= 4'h7;
              end else begin
                rsp_q.byte0 <= b; rsp_q.byte1 <= g; rsp_q.byte2 <= r;
                rsp_q.byte_mask <= 4'h7;
              end
            end
            Mode565, Mode555: begin
              rsp_q.byte0 <= endian_q ? hi : lo;
              rsp_q.byte1 <= endian_q ? lo : hi;
              rsp_q.byte_mask <= 4'h3;
            end
            default: begin
              rsp_q.byte0 <= pal;
              rsp_q.byte_mask <= 4'h1;
              st_q <= StHr;
            end
          endcase
        end
        StHr: st_q <= StHrW;
        StHrW: begin
          if (req_q.req_type == ReqRead) begin
            rsp_q.sum_red <= hist_rd_q[119:88];
            rsp_q.sum_green <= hist_rd_q[87:56];
            rsp_q.sum_blue <= hist_rd_q[55:24];
            rsp_q.hit_count <= hist_rd_q[23:0];
            st_q <= StOut;
          end else st_q <= StHupd;
        end
        StHupd: st_q <= StOut;
        StOut: if (rsp_o.ready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid)) else $error("ready while result pending");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv |-> cnt_q < 6'(DivW)) else $error("divider overrun");
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.status |-> rsp_o.data.byte_mask == 4'h0)
    else $error("flagged result carries bytes");
endmodule

// File: sim/testbench.sv
// self-checking testbench for the scanline scaler and pixel converter
`timescale 1ns / 1ps
module testbench;
  import sspc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sspc_if #(.payload_t(req_t)) req_ch ();
  sspc_if #(.payload_t(rsp_t)) rsp_ch ();

  scanline_scale_pixel_convert uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  // shadow of configuration and state
  logic [1:0] cfg_mode;
  logic cfg_big;
  logic [2:0] cfg_bpp;
  logic [12:0] cfg_srcw;
  logic [15:0] cfg_zoomw, cfg_xoff;
  logic [23:0] line_shadow [LineDepth];
  bit line_written [LineDepth];
  logic [31:0] hr_shadow [HistDepth], hg_shadow [HistDepth], hb_shadow [HistDepth];
  logic [23:0] hc_shadow [HistDepth];

  rsp_t expected_rsp_q[$];
  int fail_count = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_rsp = 1'b0;

  function automatic logic [31:0] sat32(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? SumMax : s[31:0];
  endfunction

  // source index reached by a convert, all ones when the zoom width is zero
  function automatic longint unsigned fetch_index(logic [15:0] idx);
    longint unsigned num;
    num = (longint'(idx) + cfg_xoff) * cfg_srcw;
    if (cfg_zoomw == 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return num / cfg_zoomw;
  endfunction

  // expected response to one request, updating the shadow state
  function automatic rsp_t predict_response(req_t rq);
    rsp_t o;
    longint unsigned src;
    logic [7:0] r, g, b, lo, hi, m;
    int k;
    o = '0;
    case (rq.req_type)
      ReqLoad: begin
        if (rq.pixel_index < LineDepth) begin
          line_shadow[rq.pixel_index] = {rq.red_in, rq.green_in, rq.blue_in};
          line_written[rq.pixel_index] = 1'b1;
        end else o.status = 1'b1;
      end
      ReqConv: begin
        src = fetch_index(rq.pixel_index);
        if (src >= LineDepth) o.status = 1'b1;
        else begin
          {r, g, b} = line_shadow[src];
          case (cfg_mode)
            ModeDirect: begin
              if (cfg_big) begin
                k = (cfg_bpp == 3) ? 0 : 1;
                if (k == 0) {o.byte0, o.byte1, o.byte2} = {r, g, b};
                else {o.byte1, o.byte2, o.byte3} = {r, g, b};
                o.byte_mask = 4'h7 << k;
              end else begin
                {o.byte0, o.byte1, o.byte2} = {b, g, r};
                o.byte_mask = 4'h7;
              end
            end
            Mode565, Mode555: begin
              if (cfg_mode == Mode565) begin
                lo = {g[4:2], b[7:3]};
                hi = {r[7:3], g[7:5]};
              end else begin
                lo = {g[5:3], b[7:3]};
                hi = {1'b0, r[7:3], g[7:6]};
              end
              if (cfg_big) {o.byte0, o.byte1} = {hi, lo};
              else {o.byte0, o.byte1} = {lo, hi};
              o.byte_mask = 4'h3;
            end
            default: begin
              m = 8'(((7 * g) / 256) * 36 + ((6 * r) / 256) * 6 + (6 * b) / 256);
              o.byte0 = m;
              o.byte_mask = 4'h1;
              hr_shadow[m] = sat32(hr_shadow[m], r);
              hg_shadow[m] = sat32(hg_shadow[m], g);
              hb_shadow[m] = sat32(hb_shadow[m], b);
              if (hc_shadow[m] != CntMax) hc_shadow[m] = hc_shadow[m] + 24'd1;
            end
          endcase
        end
      end
      ReqRead: begin
        if (rq.pixel_index < HistDepth) begin
          o.sum_red = hr_shadow[rq.pixel_index];
          o.sum_green = hg_shadow[rq.pixel_index];
          o.sum_blue = hb_shadow[rq.pixel_index];
          o.hit_count = hc_shadow[rq.pixel_index];
        end else o.status = 1'b1;
      end
      default: begin
        if (rq.pixel_index < HistDepth) begin
          hr_shadow[rq.pixel_index] = '0;
          hg_shadow[rq.pixel_index] = '0;
          hb_shadow[rq.pixel_index] = '0;
          hc_shadow[rq.pixel_index] = '0;
        end else o.status = 1'b1;
      end
    endcase
    return o;
  endfunction

  // register write over the config port
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegMode: cfg_mode = val[1:0];
      RegEndian: cfg_big = val[0];
      RegBpp: cfg_bpp = val[2:0];
      RegSrcW: cfg_srcw = val[12:0];
      RegZoomW: cfg_zoomw = val[15:0];
      default: cfg_xoff = val[15:0];
    endcase
  endtask

  task automatic configure(logic [1:0] mode, logic big, logic [2:0] bpp,
                           logic [12:0] srcw, logic [15:0] zoomw, logic [15:0] xoff);
    write_reg(RegMode, 32'(mode));
    write_reg(RegEndian, 32'(big));
    write_reg(RegBpp, 32'(bpp));
    write_reg(RegSrcW, 32'(srcw));
    write_reg(RegZoomW, 32'(zoomw));
    write_reg(RegXOff, 32'(xoff));
  endtask

  // one request transfer with optional leading idle cycles
  task automatic send_request(req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= rq;
    expected_rsp_q.push_back(predict_response(rq));
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
  endtask

  // convert whose fetch stays inside written entries (or beyond the store)
  function automatic bit conv_safe(logic [15:0] idx);
    longint unsigned src;
    src = fetch_index(idx);
    return src >= LineDepth || line_written[src];
  endfunction

  // receiver: random stalls, optional long hold-off
  always @(posedge clk_i) begin
    if (hold_rsp) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // response checker
  always @(posedge clk_i) begin
    rsp_t exp_r, got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t unexpected response %h", $time, got);
        fail_count++;
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_r, got);
          fail_count++;
        end
      end
    end
  end

  typedef struct {
    req_t rq;
    bit has_exp;
    rsp_t exp_r;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    req_t rq;
    rsp_t pred;
    int phase, n, hold_cycles;
    cfg_mode = ModeDirect; cfg_big = 1'b0; cfg_bpp = 3'd4;
    cfg_srcw = 13'd4096; cfg_zoomw = 16'd4096; cfg_xoff = 16'd0;
    foreach (hr_shadow[i]) begin
      hr_shadow[i] = '0; hg_shadow[i] = '0; hb_shadow[i] = '0; hc_shadow[i] = '0;
    end
    foreach (line_written[i]) line_written[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    rows.push_back('{'{ReqRead, 16'd0, 8'd0, 8'd0, 8'd0}, 1, '0});
    rows.push_back('{'{ReqRead, 16'd255, 8'd0, 8'd0, 8'd0}, 1, '0});
    rows.push_back('{'{ReqRead, 16'd256, 8'd0, 8'd0, 8'd0}, 1, rsp_t'(1)});
    rows.push_back('{'{ReqClear, 16'hFFFF, 8'd0, 8'd0, 8'd0}, 1, rsp_t'(1)});
    rows.push_back('{'{ReqLoad, 16'd4096, 8'hFF, 8'hFF, 8'hFF}, 1, rsp_t'(1)});
    rows.push_back('{'{ReqLoad, 16'd0, 8'hFF, 8'hFF, 8'hFF}, 1, '0});
    rows.push_back('{'{ReqLoad, 16'd4095, 8'h00, 8'h00, 8'h00}, 1, '0});
    rows.push_back('{'{ReqLoad, 16'd1, 8'h12, 8'h34, 8'h56}, 0, '0});
    rows.push_back('{'{ReqLoad, 16'd2, 8'hA5, 8'h5A, 8'hC3}, 0, '0});
    rows.push_back('{'{ReqConv, 16'd0, 8'd0, 8'd0, 8'd0}, 0, '0});
    rows.push_back('{'{ReqConv, 16'd1, 8'd0, 8'd0, 8'd0}, 0, '0});
    rows.push_back('{'{ReqConv, 16'd4095, 8'd0, 8'd0, 8'd0}, 0, '0});
    rows.push_back('{'{ReqConv, 16'd4096, 8'd0, 8'd0, 8'd0}, 1, rsp_t'(1)});
    rows.push_back('{'{ReqConv, 16'hFFFF, 8'd0, 8'd0, 8'd0}, 1, rsp_t'(1)});
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        pred = predict_response(rows[i].rq);
        if (pred !== rows[i].exp_r) begin
          $display("%0t table row %0d expected %h actual %h", $time, i,
                   rows[i].exp_r, pred);
          fail_count++;
        end
      end
    end
    // shadow was advanced above for checked rows; restart from reset values
    foreach (line_written[i]) line_written[i] = 1'b0;
    foreach (hr_shadow[i]) begin
      hr_shadow[i] = '0; hg_shadow[i] = '0; hb_shadow[i] = '0; hc_shadow[i] = '0;
    end
    foreach (rows[i]) send_request(rows[i].rq);
    drain();

    // every mode on the written entries, including zero zoom and odd slot size
    for (int md = 0; md < 4; md++) begin
      for (int bg = 0; bg < 2; bg++) begin
        configure(2'(md), 1'(bg), (md == 0 && bg == 1) ? 3'd7 : 3'd3, 13'd4096,
                  16'd4096, 16'd0);
        for (int px = 0; px < 3; px++) send_request('{ReqConv, px[15:0], 8'd0, 8'd0, 8'd0});
        send_request('{ReqConv, 16'd4095, 8'd0, 8'd0, 8'd0});
        drain();
      end
    end
    configure(ModePal, 1'b0, 3'd4, 13'd1, 16'd0, 16'hFFFF);
    send_request('{ReqConv, 16'd5, 8'd0, 8'd0, 8'd0});
    send_request('{ReqRead, 16'd251, 8'd0, 8'd0, 8'd0});
    send_request('{ReqClear, 16'd251, 8'd0, 8'd0, 8'd0});
    send_request('{ReqRead, 16'd251, 8'd0, 8'd0, 8'd0});
    drain();

    // fill a small source line so random converts land on written entries
    configure(ModeDirect, 1'b0, 3'd4, 13'd64, 16'd128, 16'd0);
    for (int i = 0; i < 64; i++)
      send_request('{ReqLoad, i[15:0], 8'($urandom), 8'($urandom), 8'($urandom)});
    drain();

    // random phases with different settings and idling
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (phase == 7) configure(ModePal, 1'b1, 3'd3, 13'd1, 16'd1, 16'd0);
      else configure(2'($urandom_range(3)), 1'($urandom_range(1)),
                     3'($urandom_range(3, 4)),
                     13'($urandom_range(1, 64)), 16'($urandom_range(1, 200)),
                     16'($urandom_range(0, 40)));
      if (phase == 4) begin
        // long hold-off on the response side while requests keep coming
        hold_rsp = 1'b1;
        fork
          begin
            hold_cycles = 0;
            while (hold_cycles < 300) begin @(posedge clk_i); hold_cycles++; end
            hold_rsp = 1'b0;
          end
        join_none
      end
      n = 0;
      while (n < 130) begin
        rq.pixel_index = 16'($urandom);
        rq.red_in = 8'($urandom); rq.green_in = 8'($urandom); rq.blue_in = 8'($urandom);
        case ($urandom_range(9))
          0, 1, 2: begin
            rq.req_type = ReqLoad;
            if ($urandom_range(9) != 0) rq.pixel_index = 16'($urandom_range(0, 63));
          end
          3, 4, 5, 6: begin
            rq.req_type = ReqConv;
            if ($urandom_range(7) != 0) rq.pixel_index = 16'($urandom_range(0, 80));
          end
          7, 8: begin
            rq.req_type = ReqRead;
            if ($urandom_range(7) != 0) rq.pixel_index = 16'($urandom_range(0, 255));
          end
          default: begin
            rq.req_type = ReqClear;
            if ($urandom_range(7) != 0) rq.pixel_index = 16'($urandom_range(0, 255));
          end
        endcase
        if (rq.req_type == ReqConv && !conv_safe(rq.pixel_index)) continue;
        send_request(rq);
        n++;
      end
      drain();
    end

    if (expected_rsp_q.size() != 0) begin
      $display("%0t missing responses expected %0d actual 0", $time,
               expected_rsp_q.size());
      fail_count++;
    end
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: scanline_scale_pixel_convert.f
hdl/sspc_pkg.sv
hdl/sspc_if.sv
hdl/scanline_scale_pixel_convert.sv
sim/testbench.sv
